// ----- src/alcd_pkg.sv -----
// alcd_pkg: types and constants for the ASCII length/checksum deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package alcd_pkg;

	localparam int unsigned SUM_MODULUS = 10000;
	localparam int unsigned SUM_W       = 14;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] QUIT_BYTE  = 8'h71;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_HALTED
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY       = 2'd0,
		ST_OK         = 2'd1,
		ST_BAD_SUM    = 2'd2,
		ST_BAD_HEADER = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       frame_last;
		status_t    frame_status;
		logic       quit_seen;
	} res_t;

endpackage

`default_nettype wire

// ----- src/alcd_core.sv -----
// alcd_core: frame state and per-word parse, count and checksum step.
// Depends on alcd_pkg.
`default_nettype none

module alcd_core
	import alcd_pkg::*;
#(
	parameter int unsigned FIELD_DIGITS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte_s1,
	input  wire logic       halt_cfg,
	output      logic       emit,
	output      res_t       res
);

	localparam int unsigned HEADER_BYTES = 2 * FIELD_DIGITS;
	localparam int unsigned FIELD_W      = $clog2(10 ** FIELD_DIGITS);
	localparam int unsigned MUL_W        = FIELD_W + 4;
	localparam int unsigned POS_W        = $clog2(HEADER_BYTES + 1);
	localparam int unsigned CMP_W        = (FIELD_W > SUM_W) ? FIELD_W : SUM_W;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [FIELD_W-1:0] len_q, len_d;
	logic [FIELD_W-1:0] exp_q, exp_d;
	logic [FIELD_W-1:0] rem_q, rem_d;
	logic [SUM_W-1:0]   sum_q, sum_d;

	logic               is_digit;
	logic [3:0]         digit;
	logic [POS_W-1:0]   pos_inc;
	logic               in_len;
	logic [FIELD_W-1:0] len_new, exp_new;
	logic               hdr_done, hdr_short, hdr_empty;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W-1:0]   sum_new;
	logic [FIELD_W-1:0] rem_new;
	logic               pay_last;
	logic               empty_ok, pay_ok, pay_quit;

	assign is_digit  = rx_byte_s1 inside {[ASCII_ZERO:ASCII_NINE]};
	assign digit     = rx_byte_s1[3:0];
	assign pos_inc   = pos_q + POS_W'(1);
	assign in_len    = pos_q < POS_W'(FIELD_DIGITS);
	assign len_new   = in_len ? FIELD_W'((MUL_W'(len_q) << 3) + (MUL_W'(len_q) << 1)
		+ MUL_W'(digit)) : len_q;
	assign exp_new   = in_len ? exp_q : FIELD_W'((MUL_W'(exp_q) << 3)
		+ (MUL_W'(exp_q) << 1) + MUL_W'(digit));
	assign hdr_done  = pos_inc == POS_W'(HEADER_BYTES);
	assign hdr_short = len_new < FIELD_W'(HEADER_BYTES);
	assign hdr_empty = len_new == FIELD_W'(HEADER_BYTES);
	assign empty_ok  = exp_new == '0;

	assign sum_add  = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(rx_byte_s1);
	assign sum_new  = (sum_add >= (SUM_W + 1)'(SUM_MODULUS))
		? SUM_W'(sum_add - (SUM_W + 1)'(SUM_MODULUS)) : SUM_W'(sum_add);
	assign rem_new  = (rem_q != '0) ? rem_q - FIELD_W'(1) : rem_q;
	assign pay_last = rem_new == '0;
	assign pay_ok   = CMP_W'(sum_new) == CMP_W'(exp_q);
	assign pay_quit = pay_ok && (len_q == FIELD_W'(HEADER_BYTES + 1))
		&& (rx_byte_s1 == QUIT_BYTE);

	// next state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		exp_d   = exp_q;
		rem_d   = rem_q;
		sum_d   = sum_q;
		case (phase_q)
			PH_HEADER: begin
				if (!is_digit || (hdr_done && hdr_short)) begin
					pos_d = '0;
					len_d = '0;
					exp_d = '0;
				end else if (hdr_done && hdr_empty) begin
					pos_d = '0;
					len_d = '0;
					exp_d = '0;
					if (!empty_ok && halt_cfg) begin
						phase_d = PH_HALTED;
					end
				end else if (hdr_done) begin
					pos_d   = '0;
					len_d   = len_new;
					exp_d   = exp_new;
					rem_d   = len_new - FIELD_W'(HEADER_BYTES);
					sum_d   = '0;
					phase_d = PH_PAYLOAD;
				end else begin
					pos_d = pos_inc;
					len_d = len_new;
					exp_d = exp_new;
				end
			end
			PH_PAYLOAD: begin
				if (pay_last) begin
					phase_d = ((!pay_ok || pay_quit) && halt_cfg) ? PH_HALTED : PH_HEADER;
					len_d   = '0;
					exp_d   = '0;
					rem_d   = '0;
					sum_d   = '0;
				end else begin
					rem_d = rem_new;
					sum_d = sum_new;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// result
	always_comb begin
		emit             = 1'b0;
		res.payload_byte = '0;
		res.byte_valid   = 1'b0;
		res.frame_last   = 1'b0;
		res.frame_status = ST_BUSY;
		res.quit_seen    = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (!is_digit || (hdr_done && hdr_short)) begin
					emit             = 1'b1;
					res.frame_last   = 1'b1;
					res.frame_status = ST_BAD_HEADER;
				end else if (hdr_done && hdr_empty) begin
					emit             = 1'b1;
					res.frame_last   = 1'b1;
					res.frame_status = empty_ok ? ST_OK : ST_BAD_SUM;
				end
			end
			PH_PAYLOAD: begin
				emit             = 1'b1;
				res.payload_byte = rx_byte_s1;
				res.byte_valid   = 1'b1;
				if (pay_last) begin
					res.frame_last   = 1'b1;
					res.frame_status = pay_ok ? ST_OK : ST_BAD_SUM;
					res.quit_seen    = pay_quit;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			len_q   <= '0;
			exp_q   <= '0;
			rem_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			rem_q   <= rem_d;
			sum_q   <= sum_d;
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALTED |-> !emit)
		else $error("result produced while halted");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with no bytes left");

	a_quit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && res.quit_seen) |=> phase_q != PH_PAYLOAD)
		else $error("quit frame did not end the frame");

endmodule

`default_nettype wire

// ----- src/alcd_out_reg.sv -----
// alcd_out_reg: result register with valid/ready toward the consumer.
// Depends on alcd_pkg.
`default_nettype none

module alcd_out_reg
	import alcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire res_t res_d,
	input  wire logic out_ready,
	output      logic out_valid,
	output      logic space,
	output      res_t res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign space     = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/ascii_length_checksum_deframer.sv -----
// Deframer for streams framed as ASCII decimal length and checksum fields.
// Rate: one word per cycle unless the result register is stalled. Path: input register,
// then one step of header parse or payload count and mod-10000 sum into the result
// register. Header words give no result unless the header is bad or the frame is
// empty; each payload word gives one result, the last one with the frame status.
// After a checksum mismatch or a quit frame with halt_on_failure set, words are
// still taken but dropped until reset. Depends on alcd_pkg, alcd_core, alcd_out_reg.
`default_nettype none

module ascii_length_checksum_deframer
	import alcd_pkg::*;
#(
	parameter int unsigned FIELD_DIGITS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic       halt_on_failure,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] payload_byte,
	output      logic       byte_valid,
	output      logic       frame_last,
	output      logic [1:0] frame_status,
	output      logic       quit_seen
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       halt_q;
	logic       space;
	logic       advance;
	logic       emit;
	res_t       res_d;
	res_t       res_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && space;
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			halt_q <= halt_on_failure;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	alcd_core #(
		.FIELD_DIGITS(FIELD_DIGITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (byte_s1),
		.halt_cfg   (halt_q),
		.emit       (emit),
		.res        (res_d)
	);

	alcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.res_d     (res_d),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.space     (space),
		.res_q     (res_q)
	);

	assign payload_byte = res_q.payload_byte;
	assign byte_valid   = res_q.byte_valid;
	assign frame_last   = res_q.frame_last;
	assign frame_status = res_q.frame_status;
	assign quit_seen    = res_q.quit_seen;

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_last) |-> (frame_status == ST_BUSY && !quit_seen))
		else $error("status on a word that does not end a frame");

	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (payload_byte == 8'h00 && frame_last))
		else $error("dataless result carries data or is not last");

	a_quit_good: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && quit_seen) |-> (frame_status == ST_OK && byte_valid
			&& payload_byte == QUIT_BYTE))
		else $error("quit flag on a frame that is not a good quit frame");

endmodule

`default_nettype wire

// ----- tb/ascii_length_checksum_deframer_checker.sv -----
// Checker for ascii_length_checksum_deframer: follows the byte, config and result
// channels, predicts every result word and compares it field by field.
// Depends on alcd_pkg for the status codes, phases and result layout.
`timescale 1ns / 1ps

module ascii_length_checksum_deframer_checker
	import alcd_pkg::*;
#(
	parameter int unsigned FIELD_DIGITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       halt_on_failure,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] payload_byte,
	input  logic       byte_valid,
	input  logic       frame_last,
	input  logic [1:0] frame_status,
	input  logic       quit_seen,
	output int         mismatches,
	output int         pending,
	output logic       frame_open
);

	localparam int unsigned HDR_BYTES = 2 * FIELD_DIGITS;

	logic             halt_cfg;
	phase_t           ph;
	logic [3:0]       hdr_pos;
	logic [SUM_W-1:0] len_val;
	logic [SUM_W-1:0] sum_field;
	logic [SUM_W-1:0] remaining;
	logic [SUM_W-1:0] run_sum;
	logic [7:0]       tail_byte;
	res_t             awaited_results[$];
	int               open_count = 0;
	int               fail_total = 0;
	int               result_index = 0;

	assign mismatches = fail_total;
	assign pending    = open_count;
	assign frame_open = (ph != PH_HEADER) || (hdr_pos != 0);

	task automatic report(input string msg);
		// quiet after 200 lines, still counting
		if (fail_total < 200)
			$display("[%0t] result %0d: %s", $time, result_index, msg);
		fail_total++;
	endtask

	task automatic clear_frame();
		ph        = PH_HEADER;
		hdr_pos   = '0;
		len_val   = '0;
		sum_field = '0;
		remaining = '0;
		run_sum   = '0;
		tail_byte = '0;
	endtask

	task automatic await_result(input logic [7:0] data, input logic valid, input logic last,
			input status_t st, input logic quit);
		res_t r;
		r.payload_byte = data;
		r.byte_valid   = valid;
		r.frame_last   = last;
		r.frame_status = st;
		r.quit_seen    = quit;
		awaited_results.push_back(r);
		open_count++;
	endtask

	task automatic close_frame(input logic ok, input logic [7:0] data, input logic valid);
		logic quit;
		quit = ok && (len_val == HDR_BYTES + 1) && (tail_byte == QUIT_BYTE);
		clear_frame();
		if ((!ok || quit) && halt_cfg)
			ph = PH_HALTED;
		await_result(data, valid, 1'b1, ok ? ST_OK : ST_BAD_SUM, quit);
	endtask

	task automatic deframe_word(input logic [7:0] b);
		logic [SUM_W:0] acc;
		case (ph)
		PH_HEADER: begin
			if (b < ASCII_ZERO || b > ASCII_NINE) begin
				clear_frame();
				await_result(8'h00, 1'b0, 1'b1, ST_BAD_HEADER, 1'b0);
			end else begin
				if (hdr_pos < FIELD_DIGITS)
					len_val = SUM_W'(len_val * 10 + (b - ASCII_ZERO));
				else
					sum_field = SUM_W'(sum_field * 10 + (b - ASCII_ZERO));
				hdr_pos++;
				if (hdr_pos == HDR_BYTES) begin
					if (len_val < HDR_BYTES) begin
						clear_frame();
						await_result(8'h00, 1'b0, 1'b1, ST_BAD_HEADER, 1'b0);
					end else if (len_val == HDR_BYTES) begin
						close_frame(sum_field == 0, 8'h00, 1'b0);
					end else begin
						remaining = SUM_W'(len_val - HDR_BYTES);
						run_sum   = '0;
						ph        = PH_PAYLOAD;
					end
				end
			end
		end
		PH_PAYLOAD: begin
			acc = run_sum + b;
			if (acc >= SUM_MODULUS)
				acc = acc - (SUM_W + 1)'(SUM_MODULUS);
			run_sum   = acc[SUM_W-1:0];
			tail_byte = b;
			if (remaining != 0)
				remaining--;
			if (remaining != 0)
				await_result(b, 1'b1, 1'b0, ST_BUSY, 1'b0);
			else
				close_frame(run_sum == sum_field, b, 1'b1);
		end
		default: ;
		endcase
	endtask

	task automatic check_result();
		res_t w;
		if (open_count == 0) begin
			report("result word arrived with none awaited");
		end else begin
			w = awaited_results.pop_front();
			open_count--;
			if (payload_byte !== w.payload_byte)
				report($sformatf("payload_byte %0h, expected %0h", payload_byte, w.payload_byte));
			if (byte_valid !== w.byte_valid)
				report($sformatf("byte_valid %0b, expected %0b", byte_valid, w.byte_valid));
			if (frame_last !== w.frame_last)
				report($sformatf("frame_last %0b, expected %0b", frame_last, w.frame_last));
			if (frame_status !== w.frame_status)
				report($sformatf("frame_status %0d, expected %0d", frame_status, w.frame_status));
			if (quit_seen !== w.quit_seen)
				report($sformatf("quit_seen %0b, expected %0b", quit_seen, w.quit_seen));
		end
		result_index++;
	endtask

	// results compared before the new input word is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_cfg = 1'b1;
			clear_frame();
			awaited_results.delete();
			open_count = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready)
				halt_cfg = halt_on_failure;
			if (in_valid && in_ready)
				deframe_word(rx_byte);
		end
	end

endmodule

// ----- tb/ascii_length_checksum_deframer_tb.sv -----
// Top of the ascii_length_checksum_deframer testbench: clock, reset, framed byte
// stimulus, config writes, output stalls and the verdict.
// Depends on alcd_pkg, the deframer RTL and ascii_length_checksum_deframer_checker.
`timescale 1ns / 1ps

module ascii_length_checksum_deframer_tb;
	import alcd_pkg::*;

	localparam int unsigned FIELD_DIGITS  = 4;
	localparam int unsigned HDR_BYTES     = 2 * FIELD_DIGITS;
	localparam int unsigned WRAP_BYTES    = 80;
	localparam int unsigned CLK_HALF      = 4;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT   = 1000;

	typedef logic [7:0] word_q_t[$];

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       halt_on_failure = 1'b1;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       cfg_ready;
	logic       out_valid;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic       frame_last;
	logic [1:0] frame_status;
	logic       quit_seen;

	int          fail_count;
	int          pending;
	logic        frame_open;
	bit          idling = 1'b1;
	int unsigned words_sent = 0;

	always #CLK_HALF clk = ~clk;

	ascii_length_checksum_deframer #(
		.FIELD_DIGITS(FIELD_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.halt_on_failure(halt_on_failure),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.frame_last(frame_last),
		.frame_status(frame_status),
		.quit_seen(quit_seen)
	);

	ascii_length_checksum_deframer_checker #(
		.FIELD_DIGITS(FIELD_DIGITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.halt_on_failure(halt_on_failure),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.byte_valid(byte_valid),
		.frame_last(frame_last),
		.frame_status(frame_status),
		.quit_seen(quit_seen),
		.mismatches(fail_count),
		.pending(pending),
		.frame_open(frame_open)
	);

	initial begin : sink
		forever begin
			@(posedge clk);
			if (idling && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [7:0] b);
		if (idling && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_field(input int unsigned value);
		int unsigned scale;
		scale = 1;
		repeat (FIELD_DIGITS - 1) scale *= 10;
		while (scale != 0) begin
			send_word(8'(ASCII_ZERO + (value / scale) % 10));
			scale /= 10;
		end
	endtask

	task automatic send_frame(input word_q_t body, input bit good_sum);
		int unsigned total;
		total = 0;
		foreach (body[i])
			total = (total + body[i]) % SUM_MODULUS;
		if (!good_sum)
			total = (total + $urandom_range(1, SUM_MODULUS - 1)) % SUM_MODULUS;
		send_field(body.size() + HDR_BYTES);
		send_field(total);
		foreach (body[i])
			send_word(body[i]);
	endtask

	function automatic word_q_t random_body(input int unsigned n, input bit no_quit);
		word_q_t body;
		repeat (n) body.push_back(8'($urandom_range(0, 255)));
		if (no_quit && n == 1 && body[0] == QUIT_BYTE)
			body[0] = 8'h00;
		return body;
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b >= ASCII_ZERO && b <= ASCII_NINE);
		return b;
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_halt(input logic value);
		settle();
		cfg_valid       <= 1'b1;
		halt_on_failure <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// push non-digit words until the parser sits at the start of a header
	task automatic realign();
		settle();
		while (frame_open) begin
			send_word(non_digit());
			settle();
		end
	endtask

	// safe: nothing that can stop the block
	task automatic random_frame(input bit safe);
		int unsigned roll;
		int unsigned cut;
		word_q_t     body;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			repeat ($urandom_range(1, 4))
				send_word((safe || $urandom_range(0, 3) != 0) ? non_digit() : ASCII_ZERO);
		end else if (roll < 10) begin
			cut = $urandom_range(0, HDR_BYTES - 1);
			repeat (cut) send_word(8'(ASCII_ZERO + $urandom_range(0, 9)));
			send_word(non_digit());
		end else if (roll < 14) begin
			send_field($urandom_range(0, HDR_BYTES - 1));
			send_field($urandom_range(0, SUM_MODULUS - 1));
		end else if (roll < 17) begin
			body = {};
			send_frame(body, safe || $urandom_range(0, 1) != 0);
		end else if (roll < 20 && !safe) begin
			body = {QUIT_BYTE};
			send_frame(body, $urandom_range(0, 4) != 0);
		end else if (roll < 24) begin
			send_frame(random_body($urandom_range(40, 300), safe),
				safe || $urandom_range(0, 3) != 0);
		end else begin
			send_frame(random_body($urandom_range(1, 24), safe),
				safe || $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic random_run(input int unsigned words, input bit safe, input bit steady);
		int unsigned stop_at;
		int unsigned frames;
		stop_at = words_sent + words;
		frames  = 0;
		while (words_sent < stop_at) begin
			if (frames % 16 == 0)
				idling = !steady && $urandom_range(0, 3) != 0;
			random_frame(safe);
			frames++;
			if ($urandom_range(0, 29) == 0)
				settle();
		end
	endtask

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ascii_length_checksum_deframer_tb failed");
		$finish;
	end

	initial begin : stimulus
		word_q_t body;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_halt(1'b1);
		body = {};
		send_frame(body, 1'b1);
		body = {8'h00, 8'hFF};
		send_frame(body, 1'b1);
		send_word(8'h2F);
		send_word(8'h3A);
		send_word(ASCII_ZERO);
		send_word(ASCII_NINE);
		send_word(8'h41);
		send_field(HDR_BYTES - 1);
		send_field(SUM_MODULUS - 1);

		write_halt(1'b0);
		body = {QUIT_BYTE};
		send_frame(body, 1'b1);
		body = {};
		send_frame(body, 1'b0);

		// all-ones payload wraps the sum more than once
		body = {};
		repeat (WRAP_BYTES) body.push_back(8'hFF);
		send_frame(body, 1'b1);
		random_run(750, 1'b0, 1'b0);

		realign();
		write_halt(1'b1);
		random_run(300, 1'b1, 1'b0);

		realign();
		write_halt(1'b0);
		random_run(150, 1'b0, 1'b1);

		// stop the block for good, then feed words it has to drop
		realign();
		write_halt(1'b1);
		if ($urandom_range(0, 1) != 0) begin
			body = {QUIT_BYTE};
			send_frame(body, 1'b1);
		end else begin
			send_frame(random_body($urandom_range(1, 8), 1'b0), 1'b0);
		end
		repeat (20) send_word(8'($urandom_range(0, 255)));
		settle();

		if (fail_count == 0)
			$display("ascii_length_checksum_deframer_tb passed");
		else
			$display("ascii_length_checksum_deframer_tb failed");
		$finish;
	end

endmodule
